>>> sv/minimum_covering_window_defines.svh
// Assertion macros shared by the window block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef MINIMUM_COVERING_WINDOW_DEFINES_SVH
`define MINIMUM_COVERING_WINDOW_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mcw_pkg.sv
`default_nettype none

package mcw_pkg;

    localparam int MAX_LEN_DEF = 65536;
    localparam int CODE_W      = 6;
    localparam int NUM_CODES   = 53;
    localparam int NEED_W      = 17;
    localparam int OUT_IDX_W   = 16;
    localparam logic [NEED_W-1:0] COUNT_MAX = {NEED_W{1'b1}};
    localparam logic [CODE_W-1:0] CODE_NONE = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT,
        S_TXT,
        S_BEST,
        S_FETCH,
        S_ADJ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } cnt_ctl_t;

    function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        code = CODE_NONE;
        if (ch inside {[8'h41:8'h5A]})
        begin
            code = CODE_W'(ch - 8'h40);
        end
        else if (ch inside {[8'h61:8'h7A]})
        begin
            code = CODE_W'(ch - 8'h61 + 8'd27);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> sv/mcw_text_mem.sv
`default_nettype none

module mcw_text_mem #(
    parameter int DEPTH = mcw_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [mcw_pkg::CODE_W-1:0] wr_data,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [mcw_pkg::CODE_W-1:0] rd_data
);

    logic [mcw_pkg::CODE_W-1:0] mem [DEPTH];
    logic [mcw_pkg::CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/mcw_count_mem.sv
`default_nettype none

module mcw_count_mem #(
    parameter int HAVE_W = mcw_pkg::NEED_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mcw_pkg::cnt_ctl_t           ctl,
    input  wire logic [mcw_pkg::CODE_W-1:0]  wr_addr,
    input  wire logic [mcw_pkg::NEED_W-1:0]  wr_need,
    input  wire logic [HAVE_W-1:0]           wr_have,
    input  wire logic [mcw_pkg::CODE_W-1:0]  rd_addr,
    output logic      [mcw_pkg::NEED_W-1:0]  rd_need,
    output logic      [HAVE_W-1:0]           rd_have
);

    // An entry whose valid bit is clear reads as zero, so a clear resets every entry at once.
    logic [mcw_pkg::NEED_W+HAVE_W-1:0] mem [mcw_pkg::NUM_CODES];
    logic [mcw_pkg::NUM_CODES-1:0]     valid_reg;
    logic [mcw_pkg::NEED_W+HAVE_W-1:0] rd_data_reg;
    logic                              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= {wr_need, wr_have};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_need = rd_valid_reg ? rd_data_reg[mcw_pkg::NEED_W+HAVE_W-1:HAVE_W] : '0;
    assign rd_have = rd_valid_reg ? rd_data_reg[HAVE_W-1:0] : '0;

endmodule

`default_nettype wire

>>> sv/mcw_window_ctrl.sv
`default_nettype none
`include "minimum_covering_window_defines.svh"

module mcw_window_ctrl #(
    parameter int MAX_LEN = mcw_pkg::MAX_LEN_DEF,
    parameter int AW      = $clog2(MAX_LEN),
    parameter int IW      = $clog2(MAX_LEN + 1),
    parameter int LW      = $clog2(MAX_LEN + 2),
    parameter int HAVE_W  = (LW > mcw_pkg::NEED_W) ? LW : mcw_pkg::NEED_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        command,
    input  wire logic [7:0]                  symbol,
    input  wire logic                        is_last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic [mcw_pkg::OUT_IDX_W-1:0]    window_start,
    output logic [mcw_pkg::OUT_IDX_W-1:0]    window_end,
    output logic                             overflow,
    output logic                             text_wr_en,
    output logic [AW-1:0]                    text_wr_addr,
    output logic [mcw_pkg::CODE_W-1:0]       text_wr_data,
    output logic [AW-1:0]                    text_rd_addr,
    input  wire logic [mcw_pkg::CODE_W-1:0]  text_rd_data,
    output mcw_pkg::cnt_ctl_t                cnt_ctl,
    output logic [mcw_pkg::CODE_W-1:0]       cnt_wr_addr,
    output logic [mcw_pkg::NEED_W-1:0]       cnt_wr_need,
    output logic [HAVE_W-1:0]                cnt_wr_have,
    output logic [mcw_pkg::CODE_W-1:0]       cnt_rd_addr,
    input  wire logic [mcw_pkg::NEED_W-1:0]  cnt_rd_need,
    input  wire logic [HAVE_W-1:0]           cnt_rd_have
);

    localparam logic [IW-1:0] RIGHT_FULL = IW'(MAX_LEN);
    localparam logic [LW-1:0] BEST_INIT  = LW'(MAX_LEN + 1);

    mcw_pkg::state_t              state_reg, state_next;
    logic [mcw_pkg::NEED_W-1:0]   missing_reg, missing_next;
    logic [IW-1:0]                left_reg, left_next;
    logic [IW-1:0]                right_reg, right_next;
    logic [IW-1:0]                best_start_reg, best_start_next;
    logic [IW-1:0]                best_end_reg, best_end_next;
    logic [LW-1:0]                best_len_reg, best_len_next;
    logic                         found_reg, found_next;
    logic                         overflow_reg, overflow_next;
    logic                         last_reg, last_next;
    logic [mcw_pkg::CODE_W-1:0]   code_reg, code_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg, out_found_next;
    logic [mcw_pkg::OUT_IDX_W-1:0] out_start_reg, out_start_next;
    logic [mcw_pkg::OUT_IDX_W-1:0] out_end_reg, out_end_next;
    logic                         out_overflow_reg, out_overflow_next;

    logic [mcw_pkg::CODE_W-1:0]   in_code;
    logic [mcw_pkg::CODE_W-1:0]   old_code;
    logic [HAVE_W-1:0]            need_ext;
    logic [HAVE_W-1:0]            have_dec;
    logic [IW-1:0]                win_len;
    logic                         accept;
    logic                         out_free;

    assign in_code  = mcw_pkg::letter_code(symbol);
    assign old_code = (text_rd_data >= mcw_pkg::CODE_W'(mcw_pkg::NUM_CODES))
                      ? mcw_pkg::CODE_NONE : text_rd_data;
    assign need_ext = HAVE_W'(cnt_rd_need);
    assign have_dec = cnt_rd_have - HAVE_W'(1);
    assign win_len  = right_reg - left_reg;
    assign in_stall = (state_reg != mcw_pkg::S_IDLE);
    assign accept   = in_valid && (state_reg == mcw_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign text_wr_addr = right_reg[AW-1:0];
    assign text_wr_data = in_code;
    assign text_rd_addr = left_reg[AW-1:0];
    assign cnt_wr_addr  = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mcw_pkg::S_IDLE;
            missing_reg      <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            best_start_reg   <= '0;
            best_end_reg     <= '0;
            best_len_reg     <= BEST_INIT;
            found_reg        <= 1'b0;
            overflow_reg     <= 1'b0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            missing_reg      <= missing_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            best_start_reg   <= best_start_next;
            best_end_reg     <= best_end_next;
            best_len_reg     <= best_len_next;
            found_reg        <= found_next;
            overflow_reg     <= overflow_next;
            last_reg         <= last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg         <= code_next;
        out_found_reg    <= out_found_next;
        out_start_reg    <= out_start_next;
        out_end_reg      <= out_end_next;
        out_overflow_reg <= out_overflow_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        missing_next      = missing_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        best_start_next   = best_start_reg;
        best_end_next     = best_end_reg;
        best_len_next     = best_len_reg;
        found_next        = found_reg;
        overflow_next     = overflow_reg;
        last_next         = last_reg;
        code_next         = code_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_found_next    = out_found_reg;
        out_start_next    = out_start_reg;
        out_end_next      = out_end_reg;
        out_overflow_next = out_overflow_reg;
        text_wr_en        = 1'b0;
        cnt_ctl           = '0;
        cnt_wr_need       = cnt_rd_need;
        cnt_wr_have       = cnt_rd_have;
        cnt_rd_addr       = in_code;

        case (state_reg)
            mcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    code_next = in_code;
                    if (!command)
                    begin
                        if ((right_reg == '0) && (in_code != mcw_pkg::CODE_NONE)
                            && (missing_reg != mcw_pkg::COUNT_MAX))
                        begin
                            state_next = mcw_pkg::S_PAT;
                        end
                    end
                    else
                    begin
                        last_next = is_last;
                        if (right_reg != RIGHT_FULL)
                        begin
                            text_wr_en = 1'b1;
                            right_next = right_reg + IW'(1);
                            state_next = mcw_pkg::S_TXT;
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                            if (is_last)
                            begin
                                state_next = mcw_pkg::S_DONE;
                            end
                        end
                    end
                end
            end

            mcw_pkg::S_PAT:
            begin
                cnt_ctl.wr_en = 1'b1;
                cnt_wr_need   = cnt_rd_need + mcw_pkg::NEED_W'(1);
                missing_next  = missing_reg + mcw_pkg::NEED_W'(1);
                state_next    = mcw_pkg::S_IDLE;
            end

            mcw_pkg::S_TXT:
            begin
                state_next = last_reg ? mcw_pkg::S_DONE : mcw_pkg::S_IDLE;
                if (cnt_rd_need != '0)
                begin
                    cnt_ctl.wr_en = 1'b1;
                    cnt_wr_have   = cnt_rd_have + HAVE_W'(1);
                    if (cnt_rd_have < need_ext)
                    begin
                        missing_next = missing_reg - mcw_pkg::NEED_W'(1);
                    end
                    if ((missing_next == '0) && (left_reg < right_reg))
                    begin
                        state_next = mcw_pkg::S_BEST;
                    end
                end
            end

            mcw_pkg::S_BEST:
            begin
                if (LW'(win_len) < best_len_reg)
                begin
                    best_start_next = left_reg;
                    best_end_next   = right_reg - IW'(1);
                    best_len_next   = LW'(win_len);
                    found_next      = 1'b1;
                end
                state_next = mcw_pkg::S_FETCH;
            end

            mcw_pkg::S_FETCH:
            begin
                code_next   = old_code;
                cnt_rd_addr = old_code;
                state_next  = mcw_pkg::S_ADJ;
            end

            mcw_pkg::S_ADJ:
            begin
                left_next  = left_reg + IW'(1);
                if (cnt_rd_need != '0)
                begin
                    cnt_ctl.wr_en = 1'b1;
                    cnt_wr_have   = have_dec;
                    if (have_dec < need_ext)
                    begin
                        missing_next = missing_reg + mcw_pkg::NEED_W'(1);
                    end
                end
                if ((missing_next == '0) && (left_next < right_reg))
                begin
                    state_next = mcw_pkg::S_BEST;
                end
                else
                begin
                    state_next = last_reg ? mcw_pkg::S_DONE : mcw_pkg::S_IDLE;
                end
            end

            mcw_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_found_next    = found_reg;
                    out_start_next    = mcw_pkg::OUT_IDX_W'(best_start_reg);
                    out_end_next      = mcw_pkg::OUT_IDX_W'(best_end_reg);
                    out_overflow_next = overflow_reg;
                    cnt_ctl.clear     = 1'b1;
                    missing_next      = '0;
                    left_next         = '0;
                    right_next        = '0;
                    best_start_next   = '0;
                    best_end_next     = '0;
                    best_len_next     = BEST_INIT;
                    found_next        = 1'b0;
                    overflow_next     = 1'b0;
                    last_next         = 1'b0;
                    state_next        = mcw_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mcw_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign window_start = out_start_reg;
    assign window_end   = out_end_reg;
    assign overflow     = out_overflow_reg;

    `MCW_ASSERT_NOW(a_left_within_right, 1'b1, left_reg <= right_reg,
        "left index passed right index")
    `MCW_ASSERT_NOW(a_best_fits_text, found_reg, LW'(best_len_reg) <= LW'(right_reg),
        "best window longer than the stored text")
    `MCW_ASSERT_NOW(a_have_no_underflow,
        (state_reg == mcw_pkg::S_ADJ) && (cnt_rd_need != '0), cnt_rd_have != '0,
        "window releases a letter it does not hold")
    `MCW_ASSERT_NEXT(a_result_loaded, (state_reg == mcw_pkg::S_DONE) && out_free,
        out_valid_reg && (state_reg == mcw_pkg::S_IDLE) && (right_reg == '0),
        "result not loaded or state not cleared")

endmodule

`default_nettype wire

>>> sv/minimum_covering_window.sv
// Channel  Direction  Handshake            Fields
// input    in         in_valid, in_stall   command, symbol, is_last
// output   out        out_valid, out_stall found, window_start, window_end, overflow
//
// A counted pattern word takes a read and a write back of the count memory.
// An ignored pattern word and a dropped text word are handled in the idle state.
// A text word reads and writes back its count; each letter that leaves the window on
// the left then needs the text memory read and the count memory read-modify-write.
// After the last text word the result is loaded and all counts are cleared at once.
// Reset clears the counts through per-entry valid bits, so no clearing pass follows it.
// A stalled result holds the block in its final step until the output register frees.
`default_nettype none

module minimum_covering_window #(
    parameter int MAX_LEN = mcw_pkg::MAX_LEN_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      command,
    input  wire logic [7:0]                symbol,
    input  wire logic                      is_last,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic [mcw_pkg::OUT_IDX_W-1:0]  window_start,
    output logic [mcw_pkg::OUT_IDX_W-1:0]  window_end,
    output logic                           overflow
);

    localparam int AW     = $clog2(MAX_LEN);
    localparam int IW     = $clog2(MAX_LEN + 1);
    localparam int LW     = $clog2(MAX_LEN + 2);
    localparam int HAVE_W = (LW > mcw_pkg::NEED_W) ? LW : mcw_pkg::NEED_W;

    logic                        text_wr_en;
    logic [AW-1:0]               text_wr_addr;
    logic [mcw_pkg::CODE_W-1:0]  text_wr_data;
    logic [AW-1:0]               text_rd_addr;
    logic [mcw_pkg::CODE_W-1:0]  text_rd_data;
    mcw_pkg::cnt_ctl_t           cnt_ctl;
    logic [mcw_pkg::CODE_W-1:0]  cnt_wr_addr;
    logic [mcw_pkg::NEED_W-1:0]  cnt_wr_need;
    logic [HAVE_W-1:0]           cnt_wr_have;
    logic [mcw_pkg::CODE_W-1:0]  cnt_rd_addr;
    logic [mcw_pkg::NEED_W-1:0]  cnt_rd_need;
    logic [HAVE_W-1:0]           cnt_rd_have;

    mcw_text_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_text_mem (
        .clk     (clk),
        .wr_en   (text_wr_en),
        .wr_addr (text_wr_addr),
        .wr_data (text_wr_data),
        .rd_addr (text_rd_addr),
        .rd_data (text_rd_data)
    );

    mcw_count_mem #(
        .HAVE_W (HAVE_W)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cnt_ctl),
        .wr_addr (cnt_wr_addr),
        .wr_need (cnt_wr_need),
        .wr_have (cnt_wr_have),
        .rd_addr (cnt_rd_addr),
        .rd_need (cnt_rd_need),
        .rd_have (cnt_rd_have)
    );

    mcw_window_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .IW      (IW),
        .LW      (LW),
        .HAVE_W  (HAVE_W)
    ) u_window_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .symbol       (symbol),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .window_start (window_start),
        .window_end   (window_end),
        .overflow     (overflow),
        .text_wr_en   (text_wr_en),
        .text_wr_addr (text_wr_addr),
        .text_wr_data (text_wr_data),
        .text_rd_addr (text_rd_addr),
        .text_rd_data (text_rd_data),
        .cnt_ctl      (cnt_ctl),
        .cnt_wr_addr  (cnt_wr_addr),
        .cnt_wr_need  (cnt_wr_need),
        .cnt_wr_have  (cnt_wr_have),
        .cnt_rd_addr  (cnt_rd_addr),
        .cnt_rd_need  (cnt_rd_need),
        .cnt_rd_have  (cnt_rd_have)
    );

endmodule

`default_nettype wire
